// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker module of the clipper.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is held.
`define PPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clipper check failed");

// Next-cycle implication, quiet while reset is held.
`define PPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clipper check failed");

`endif

// ===== hdl/ppc_pkg.sv =====
// Types, constants and helpers of the single-plane polygon clipper.
// No dependencies; used by the core, its checker and the bench.
package ppc_pkg;

  localparam int CW      = 32;          // coordinate width, Q16.16
  localparam int FB      = 16;          // fraction bits
  localparam int TB      = CW + 2;      // fraction bits of t
  localparam int DW      = 2 * CW + 3;  // plane distance (dot product) width
  localparam int XW      = DW + 1;      // numerator / denominator width
  localparam int MA      = TB + 1;      // multiplier operand A width
  localparam int MB      = CW + 1;      // multiplier operand B width
  localparam int PW      = MA + MB;     // product width
  localparam int EPS_W   = 17;
  localparam int KW      = XW + EPS_W;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 5;
  localparam int RIDX_W  = 3;

  localparam logic [EPS_W-1:0] EPS_RECIP = EPS_W'(100000);  // 1 / 0.00001
  localparam logic [CW-1:0]    ONE_Q     = CW'(1) << FB;

  localparam logic [RIDX_W-1:0] REG_NORMAL_X    = 3'd0;
  localparam logic [RIDX_W-1:0] REG_NORMAL_Y    = 3'd1;
  localparam logic [RIDX_W-1:0] REG_NORMAL_Z    = 3'd2;
  localparam logic [RIDX_W-1:0] REG_BASE_X      = 3'd3;
  localparam logic [RIDX_W-1:0] REG_BASE_Y      = 3'd4;
  localparam logic [RIDX_W-1:0] REG_BASE_Z      = 3'd5;
  localparam logic [RIDX_W-1:0] REG_INSIDE_REF_Z = 3'd6;

  typedef logic [2:0][CW-1:0] vec_t;

  typedef struct packed {
    logic signed [CW-1:0] vx;
    logic signed [CW-1:0] vy;
    logic signed [CW-1:0] vz;
    logic                 last_vertex;
  } in_beat_t;

  typedef struct packed {
    logic signed [CW-1:0] ox;
    logic signed [CW-1:0] oy;
    logic signed [CW-1:0] oz;
    logic                 is_intersection;
    logic                 end_of_run;
    logic                 end_of_polygon;
    logic                 edge_parallel;
    logic                 t_out_of_range;
  } out_beat_t;

  // On the same side when the sign product is not negative.
  function automatic logic sides_agree(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic a_pos, b_pos;
    a_pos = !a[DW-1] && (a != '0);
    b_pos = !b[DW-1] && (b != '0);
    return !((a[DW-1] && b_pos) || (a_pos && b[DW-1]));
  endfunction

  function automatic out_beat_t mk_res(input vec_t v, input logic isect,
                                       input logic par, input logic oor);
    out_beat_t o;
    o                 = '0;
    o.ox              = v[0];
    o.oy              = v[1];
    o.oz              = v[2];
    o.is_intersection = isect;
    o.edge_parallel   = par;
    o.t_out_of_range  = oor;
    return o;
  endfunction

endpackage

// ===== hdl/polygon_plane_clipper_core.sv =====
// Single-plane polygon clipper: APB register file, sequencer and shared datapath.
// Depends on ppc_pkg.
//
// Vertices stream in one beat each, the last of a polygon marked by last_vertex;
// clipped vertices stream out, the last beat of each input flagged end_of_run and,
// on the final input, end_of_polygon. All maths is exact integer Q16.16. One
// vertex is taken at a time (in_ready only in idle). Per input, the plane
// distance is summed on the shared multiplier (on a polygon's first vertex
// for the inside reference point as well); each intersection runs the
// 34-step restoring divider for t when t lies between zero and one, followed
// by three multiply/round steps on the same multiplier. The third vertex of a
// polygon walks the first edge, its own and, if last, the closing one; output
// stalls hold the sequencer. One result is held back so that end_of_run can be
// set on the last; a finished beat waits in the output register while the next
// vertex is taken. Registers sit at byte address 4*i (normal x,y,z, base x,y,z,
// inside reference z); pready is tied high.
module polygon_plane_clipper_core
  import ppc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_beat_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_beat_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DOT   = 9'b000000010,
    S_PLAN  = 9'b000000100,
    S_XSET  = 9'b000001000,
    S_EPS   = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_LERP  = 9'b001000000,
    S_PUSH  = 9'b010000000,
    S_FLUSH = 9'b100000000
  } state_t;

  // Step of the per-vertex plan.
  typedef enum logic [4:0] {
    PH_HEAD  = 5'b00001,
    PH_E1    = 5'b00010,
    PH_E2    = 5'b00100,
    PH_CLOSE = 5'b01000,
    PH_DONE  = 5'b10000
  } phase_t;

  localparam logic [2:0] DOT_END_CUR = 3'd2;
  localparam logic [2:0] DOT_END_REF = 3'd5;
  localparam int         DCNT_W      = $clog2(TB);

  // registers
  vec_t              nrm_r, base_r;
  logic [CW-1:0]     irz_r;
  state_t            state_r;
  phase_t            ph_r;
  logic [1:0]        cnt_r;
  logic              pin_r, last_r, emit_c_r, mph_r;
  logic [2:0]        idx_r;
  vec_t              cur_r, first_r, second_r, prev_r, x0_r, x1_r, lerp_r;
  logic [DW-1:0]     dcur_r, dref_r, dfirst_r, dsecond_r, dprev_r, xd0_r, xd1_r;
  logic [PW-1:0]     prod_r;
  logic              neg_r;
  logic [MA-1:0]     tq_r;
  logic [XW:0]       rem_r;
  logic [XW-1:0]     dm_r, e_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic              oor_r;
  out_beat_t         res_r, pend_r, out_r;
  logic              pend_vld_r, out_valid_r;

  // combinational
  logic              wr_en;
  logic [RIDX_W-1:0] ridx;
  logic [1:0]        lane;
  logic [CW-1:0]     opc;
  logic signed [CW:0] diff, ldiff, nrm_x;
  logic [CW:0]       diff_mag, ldiff_mag, nrm_mag;
  logic [MA-1:0]     mag_a;
  logic [MB-1:0]     mag_b;
  logic              mul_neg;
  logic [PW-1:0]     mul_p;
  logic [DW-1:0]     term, acc_add;
  logic [PW-1:0]     rnd;
  logic [CW-1:0]     off, lval;
  logic signed [XW-1:0] xnum, xden;
  logic [XW-1:0]     xnm, xdm;
  logic [XW:0]       sh;
  logic [KW-1:0]     kprod;
  vec_t              ep, ec;
  logic [DW-1:0]     dpe, dce;
  logic              edge_ss, out_free, out_load;
  phase_t            ph_adv;
  out_beat_t         fin_beat;

  assign wr_en     = psel && penable && pwrite && pready;
  assign ridx      = paddr[ADDR_W-1:2];
  assign pready    = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;
  // held beat moves into the output register
  assign out_load  = pend_vld_r && out_free && (state_r == S_PUSH || state_r == S_FLUSH);

  // last beat of the vertex carries the run / polygon marks
  always_comb begin
    fin_beat                = pend_r;
    fin_beat.end_of_run     = 1'b1;
    fin_beat.end_of_polygon = last_r;
  end

  always_comb begin
    unique case (ridx)
      REG_NORMAL_X:     prdata = nrm_r[0];
      REG_NORMAL_Y:     prdata = nrm_r[1];
      REG_NORMAL_Z:     prdata = nrm_r[2];
      REG_BASE_X:       prdata = base_r[0];
      REG_BASE_Y:       prdata = base_r[1];
      REG_BASE_Z:       prdata = base_r[2];
      REG_INSIDE_REF_Z: prdata = irz_r;
      default:          prdata = '0;
    endcase
  end

  // Shared multiplier operands: plane distance terms, or t * (p1 - p0).
  always_comb begin
    lane = idx_r[1:0];
    if (state_r == S_DOT && idx_r > DOT_END_CUR) lane = 2'(idx_r - 3'd3);
    if (idx_r <= DOT_END_CUR) opc = cur_r[lane];
    else                      opc = (lane == 2'd2) ? irz_r : '0;
    diff      = $signed({opc[CW-1], opc}) - $signed({base_r[lane][CW-1], base_r[lane]});
    ldiff     = $signed({x1_r[lane][CW-1], x1_r[lane]}) - $signed({x0_r[lane][CW-1], x0_r[lane]});
    nrm_x     = $signed({nrm_r[lane][CW-1], nrm_r[lane]});
    diff_mag  = diff[CW]  ? (CW+1)'(-diff)  : diff;
    ldiff_mag = ldiff[CW] ? (CW+1)'(-ldiff) : ldiff;
    nrm_mag   = nrm_x[CW] ? (CW+1)'(-nrm_x) : nrm_x;
    if (state_r == S_DOT) begin
      mag_a   = MA'(nrm_mag);
      mag_b   = diff_mag;
      mul_neg = diff[CW] ^ nrm_x[CW];
    end else begin
      mag_a   = tq_r;
      mag_b   = ldiff_mag;
      mul_neg = ldiff[CW];
    end
    mul_p   = mag_a * mag_b;
    term    = prod_r[DW-1:0];
    acc_add = neg_r ? DW'(-term) : term;
    // round half away from zero on the magnitude
    rnd     = prod_r + (PW'(1) << (TB - 1));
    off     = rnd[TB +: CW];
    lval    = neg_r ? (x0_r[lane] - off) : (x0_r[lane] + off);
  end

  // Intersection set-up: t = -d0 / (d1 - d0).
  always_comb begin
    xnum  = -$signed({xd0_r[DW-1], xd0_r});
    xden  = $signed({xd1_r[DW-1], xd1_r}) - $signed({xd0_r[DW-1], xd0_r});
    xnm   = xnum[XW-1] ? XW'(-xnum) : xnum;
    xdm   = xden[XW-1] ? XW'(-xden) : xden;
    sh    = {rem_r[XW-1:0], 1'b0};
    kprod = KW'(e_r) * KW'(EPS_RECIP);
  end

  // Edge endpoints for the current plan step.
  always_comb begin
    ep  = first_r;
    ec  = second_r;
    dpe = dfirst_r;
    dce = dsecond_r;
    if (ph_r == PH_E1 && cnt_r == 2'd3) begin
      ep  = prev_r;
      ec  = cur_r;
      dpe = dprev_r;
      dce = dcur_r;
    end else if (ph_r == PH_E2) begin
      ep  = second_r;
      ec  = cur_r;
      dpe = dsecond_r;
      dce = dcur_r;
    end else if (ph_r == PH_CLOSE) begin
      ep  = cur_r;
      ec  = first_r;
      dpe = dcur_r;
      dce = dfirst_r;
    end
    edge_ss = sides_agree(dpe, dce);
    ph_adv  = (ph_r == PH_E1) ? PH_E2 : PH_CLOSE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nrm_r       <= {ONE_Q, CW'(0), CW'(0)};
      base_r      <= '0;
      irz_r       <= ONE_Q;
      state_r     <= S_IDLE;
      ph_r        <= PH_HEAD;
      cnt_r       <= '0;
      pin_r       <= 1'b0;
      emit_c_r    <= 1'b0;
      mph_r       <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        case (ridx)
          REG_NORMAL_X:     nrm_r[0]  <= pwdata[CW-1:0];
          REG_NORMAL_Y:     nrm_r[1]  <= pwdata[CW-1:0];
          REG_NORMAL_Z:     nrm_r[2]  <= pwdata[CW-1:0];
          REG_BASE_X:       base_r[0] <= pwdata[CW-1:0];
          REG_BASE_Y:       base_r[1] <= pwdata[CW-1:0];
          REG_BASE_Z:       base_r[2] <= pwdata[CW-1:0];
          REG_INSIDE_REF_Z: irz_r     <= pwdata[CW-1:0];
          default:          ;
        endcase
      end

      if (out_load)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cur_r  <= {in_data.vz, in_data.vy, in_data.vx};
            last_r <= in_data.last_vertex;
            if (cnt_r == 2'd0) first_r  <= {in_data.vz, in_data.vy, in_data.vx};
            if (cnt_r == 2'd1) second_r <= {in_data.vz, in_data.vy, in_data.vx};
            dcur_r  <= '0;
            dref_r  <= '0;
            idx_r   <= '0;
            mph_r   <= 1'b0;
            state_r <= S_DOT;
          end
        end

        S_DOT: begin
          if (!mph_r) begin
            prod_r <= mul_p;
            neg_r  <= mul_neg;
            mph_r  <= 1'b1;
          end else begin
            mph_r <= 1'b0;
            idx_r <= idx_r + 3'd1;
            if (idx_r <= DOT_END_CUR) dcur_r <= dcur_r + acc_add;
            else                      dref_r <= dref_r + acc_add;
            if ((idx_r == DOT_END_CUR && cnt_r != 2'd0) || idx_r == DOT_END_REF) begin
              ph_r     <= PH_HEAD;
              emit_c_r <= 1'b0;
              state_r  <= S_PLAN;
            end
          end
        end

        S_PLAN: begin
          unique case (ph_r)
            PH_HEAD: begin
              ph_r <= PH_E1;
              if (cnt_r == 2'd0) begin
                pin_r <= sides_agree(dcur_r, dref_r);
                if (last_r) begin
                  res_r   <= mk_res(cur_r, 1'b0, 1'b0, 1'b0);
                  state_r <= S_PUSH;
                end
              end else if ((cnt_r == 2'd1 && last_r) || (cnt_r == 2'd2 && pin_r)) begin
                res_r   <= mk_res(first_r, 1'b0, 1'b0, 1'b0);
                state_r <= S_PUSH;
              end
            end
            PH_E1, PH_E2: begin
              if ((ph_r == PH_E1 && cnt_r[1]) || (ph_r == PH_E2 && cnt_r == 2'd2)) begin
                if (emit_c_r) begin
                  emit_c_r <= 1'b0;
                  ph_r     <= ph_adv;
                  res_r    <= mk_res(ec, 1'b0, 1'b0, 1'b0);
                  state_r  <= S_PUSH;
                end else if (pin_r) begin
                  ph_r <= ph_adv;
                  if (edge_ss) begin
                    res_r   <= mk_res(ec, 1'b0, 1'b0, 1'b0);
                    state_r <= S_PUSH;
                  end else begin
                    pin_r   <= 1'b0;
                    x0_r    <= ep;
                    x1_r    <= ec;
                    xd0_r   <= dpe;
                    xd1_r   <= dce;
                    state_r <= S_XSET;
                  end
                end else if (!edge_ss) begin
                  // leaving the outside: crossing, then the vertex itself
                  pin_r    <= 1'b1;
                  emit_c_r <= 1'b1;
                  x0_r     <= ep;
                  x1_r     <= ec;
                  xd0_r    <= dpe;
                  xd1_r    <= dce;
                  state_r  <= S_XSET;
                end else begin
                  ph_r <= ph_adv;
                end
              end else begin
                ph_r <= ph_adv;
                if (ph_r == PH_E1 && cnt_r == 2'd1 && last_r) begin
                  res_r   <= mk_res(cur_r, 1'b0, 1'b0, 1'b0);
                  state_r <= S_PUSH;
                end
              end
            end
            PH_CLOSE: begin
              // closing edge, last vertex back to the first
              ph_r <= PH_DONE;
              if (cnt_r[1] && last_r && !edge_ss) begin
                x0_r    <= ep;
                x1_r    <= ec;
                xd0_r   <= dpe;
                xd1_r   <= dce;
                state_r <= S_XSET;
              end
            end
            PH_DONE: state_r <= S_FLUSH;
            default: state_r <= S_FLUSH;
          endcase
        end

        S_XSET: begin
          rem_r  <= {1'b0, xnm};
          dm_r   <= xdm;
          dcnt_r <= '0;
          idx_r  <= '0;
          mph_r  <= 1'b0;
          if (xden == '0) begin
            res_r   <= mk_res(x0_r, 1'b1, 1'b1, 1'b0);
            state_r <= S_PUSH;
          end else if (xnum != '0 && xnum[XW-1] != xden[XW-1]) begin
            tq_r    <= '0;                 // t below zero, clamped
            e_r     <= xnm;
            state_r <= S_EPS;
          end else if (xnm >= xdm) begin
            tq_r    <= MA'(1) << TB;       // t at or above one, clamped
            e_r     <= xnm - xdm;
            state_r <= S_EPS;
          end else begin
            tq_r    <= '0;
            oor_r   <= 1'b0;
            state_r <= S_DIV;
          end
        end

        S_EPS: begin
          oor_r   <= (kprod > KW'(dm_r));
          state_r <= S_LERP;
        end

        S_DIV: begin
          if (sh >= {1'b0, dm_r}) begin
            rem_r <= sh - {1'b0, dm_r};
            tq_r  <= {tq_r[MA-2:0], 1'b1};
          end else begin
            rem_r <= sh;
            tq_r  <= {tq_r[MA-2:0], 1'b0};
          end
          dcnt_r <= dcnt_r + DCNT_W'(1);
          if (dcnt_r == DCNT_W'(TB - 1)) state_r <= S_LERP;
        end

        S_LERP: begin
          if (!mph_r) begin
            prod_r <= mul_p;
            neg_r  <= mul_neg;
            mph_r  <= 1'b1;
          end else begin
            mph_r        <= 1'b0;
            idx_r        <= idx_r + 3'd1;
            lerp_r[lane] <= lval;
            if (idx_r == DOT_END_CUR) begin
              res_r   <= mk_res({lval, lerp_r[1], lerp_r[0]}, 1'b1, 1'b0, oor_r);
              state_r <= S_PUSH;
            end
          end
        end

        S_PUSH: begin
          if (!pend_vld_r) begin
            pend_r     <= res_r;
            pend_vld_r <= 1'b1;
            state_r    <= S_PLAN;
          end else if (out_free) begin
            out_r   <= pend_r;
            pend_r  <= res_r;
            state_r <= S_PLAN;
          end
        end

        S_FLUSH: begin
          if (!pend_vld_r || out_free) begin
            if (pend_vld_r) begin
              out_r      <= fin_beat;
              pend_vld_r <= 1'b0;
            end
            prev_r  <= cur_r;
            dprev_r <= dcur_r;
            if (cnt_r == 2'd0) dfirst_r  <= dcur_r;
            if (cnt_r == 2'd1) dsecond_r <= dcur_r;
            if (last_r)              cnt_r <= '0;
            else if (cnt_r != 2'd3)  cnt_r <= cnt_r + 2'd1;
            state_r <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/ppc_checker.sv =====
// Port-level checks of the clipper core, bound onto every instance.
// Depends on ppc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ppc_checker
  import ppc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_beat_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data
);

  // stalled result beat holds
  `PPC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  // busy on the cycle after a vertex is taken
  `PPC_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready)
  // polygon end is always the end of a run
  `PPC_ASSERT_NOW(a_eop, clk, rst_n, out_valid && out_data.end_of_polygon, out_data.end_of_run)
  // flags only on intersections, never both
  `PPC_ASSERT_NOW(a_flags, clk, rst_n, out_valid && (out_data.edge_parallel || out_data.t_out_of_range), out_data.is_intersection && !(out_data.edge_parallel && out_data.t_out_of_range))

endmodule

bind polygon_plane_clipper_core ppc_checker u_ppc_checker (.*);

// ===== test/tb.sv =====
// Self-checking bench for polygon_plane_clipper_core: directed polygons, then random ones.
// Depends on ppc_pkg and the core; has its own model of the clipper to predict results.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ppc_pkg::*;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [CW-1:0] pt_t [3];

  typedef struct {
    in_beat_t  v;
    logic      typed;   // expected beat written out below
    out_beat_t res;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_beat_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_beat_t         out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  polygon_plane_clipper_core u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #2 clk = ~clk;

  // Plane set-up and polygon walk state held by the model
  logic signed [CW-1:0] plane_n [3];
  logic signed [CW-1:0] plane_b [3];
  logic signed [CW-1:0] ref_z;
  pt_t  first_v, second_v, prev_v;
  logic prev_in;
  int   vert_pos;

  out_beat_t clip_q [$];    // results of the current vertex
  out_beat_t pending_q [$]; // results still owed by the core

  int in_idle_pct = 0, out_idle_pct = 0;
  int n_fail = 0, n_beats_in = 0, n_beats_out = 0, n_isect = 0, n_polys = 0;

  always @(negedge clk) out_ready <= ($urandom_range(99) >= out_idle_pct);

  function automatic wide_t plane_dist(pt_t p);
    wide_t s = 0;
    for (int i = 0; i < 3; i++)
      s += (wide_t'(p[i]) - wide_t'(plane_b[i])) * wide_t'(plane_n[i]);
    return s;
  endfunction

  function automatic logic same_sign(wide_t a, wide_t b);
    return !((a < 0 && b > 0) || (a > 0 && b < 0));
  endfunction

  function automatic out_beat_t vtx_beat(pt_t p, logic isect, logic par, logic oor);
    out_beat_t o = '0;
    o.ox = p[0]; o.oy = p[1]; o.oz = p[2];
    o.is_intersection = isect;
    o.edge_parallel = par;
    o.t_out_of_range = oor;
    return o;
  endfunction

  // Edge/plane crossing: t = -d0/(d1-d0) to TB fraction bits, then rounded lerp.
  function automatic out_beat_t crossing(pt_t p0, pt_t p1);
    wide_t d0, num, den, nm, dm, tq, a, mag, off;
    logic  oor = 1'b0;
    pt_t   r;
    d0  = plane_dist(p0);
    num = -d0;
    den = plane_dist(p1) - d0;
    if (den == 0) return vtx_beat(p0, 1'b1, 1'b1, 1'b0);
    nm = (num < 0) ? -num : num;
    dm = (den < 0) ? -den : den;
    tq = 0;
    if (num != 0 && ((num < 0) != (den < 0))) begin
      oor = (nm * 100000) > dm;
    end else if (nm >= dm) begin
      tq  = wide_t'(1) <<< TB;
      oor = ((nm - dm) * 100000) > dm;
    end else begin
      tq = (nm <<< TB) / dm;
    end
    for (int i = 0; i < 3; i++) begin
      a    = wide_t'(p1[i]) - wide_t'(p0[i]);
      mag  = (a < 0) ? -a : a;
      off  = (tq * mag + (wide_t'(1) <<< (TB - 1))) >>> TB;
      r[i] = (a < 0) ? p0[i] - off[CW-1:0] : p0[i] + off[CW-1:0];
    end
    return vtx_beat(r, 1'b1, 1'b0, oor);
  endfunction

  function automatic void walk_edge(pt_t p, pt_t c);
    logic ss = same_sign(plane_dist(p), plane_dist(c));
    if (prev_in) begin
      if (ss) clip_q.push_back(vtx_beat(c, 1'b0, 1'b0, 1'b0));
      else begin
        clip_q.push_back(crossing(p, c));
        prev_in = 1'b0;
      end
    end else if (!ss) begin
      clip_q.push_back(crossing(p, c));
      clip_q.push_back(vtx_beat(c, 1'b0, 1'b0, 1'b0));
      prev_in = 1'b1;
    end
  endfunction

  // Fills clip_q with what one vertex beat produces and advances the walk.
  function automatic void clip_vertex(in_beat_t b);
    pt_t cur, refp;
    cur[0] = b.vx; cur[1] = b.vy; cur[2] = b.vz;
    clip_q.delete();
    if (vert_pos == 0) begin
      refp[0] = '0; refp[1] = '0; refp[2] = ref_z;
      first_v = cur;
      prev_in = same_sign(plane_dist(cur), plane_dist(refp));
      if (b.last_vertex) clip_q.push_back(vtx_beat(cur, 1'b0, 1'b0, 1'b0));
    end else if (vert_pos == 1) begin
      second_v = cur;
      if (b.last_vertex) begin
        clip_q.push_back(vtx_beat(first_v, 1'b0, 1'b0, 1'b0));
        clip_q.push_back(vtx_beat(cur, 1'b0, 1'b0, 1'b0));
      end
    end else begin
      if (vert_pos == 2) begin
        if (prev_in) clip_q.push_back(vtx_beat(first_v, 1'b0, 1'b0, 1'b0));
        walk_edge(first_v, second_v);
        walk_edge(second_v, cur);
      end else begin
        walk_edge(prev_v, cur);
      end
      // closing edge back to the first vertex
      if (b.last_vertex && !same_sign(plane_dist(cur), plane_dist(first_v)))
        clip_q.push_back(crossing(cur, first_v));
    end
    prev_v = cur;
    if (b.last_vertex) vert_pos = 0;
    else if (vert_pos < 3) vert_pos++;
    if (clip_q.size() > 0) begin
      clip_q[$].end_of_run = 1'b1;
      clip_q[$].end_of_polygon = b.last_vertex;
    end
  endfunction

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_beats_out++;
      if (pending_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 10) $display("unexpected beat %p", out_data);
      end else begin
        out_beat_t e;
        e = pending_q.pop_front();
        if (e.is_intersection) n_isect++;
        if (out_data.ox !== e.ox || out_data.oy !== e.oy || out_data.oz !== e.oz ||
            out_data.is_intersection !== e.is_intersection ||
            out_data.end_of_run !== e.end_of_run ||
            out_data.end_of_polygon !== e.end_of_polygon ||
            out_data.edge_parallel !== e.edge_parallel ||
            out_data.t_out_of_range !== e.t_out_of_range) begin
          n_fail++;
          if (n_fail <= 10) $display("mismatch: expected %p, got %p", e, out_data);
        end
      end
    end
  end

  // APB write: setup then access phase; the model takes the value too.
  task automatic reg_write(logic [RIDX_W-1:0] idx, logic [DATA_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_NORMAL_X:     plane_n[0] = val;
      REG_NORMAL_Y:     plane_n[1] = val;
      REG_NORMAL_Z:     plane_n[2] = val;
      REG_BASE_X:       plane_b[0] = val;
      REG_BASE_Y:       plane_b[1] = val;
      REG_BASE_Z:       plane_b[2] = val;
      REG_INSIDE_REF_Z: ref_z = val;
      default: ;
    endcase
  endtask

  // One vertex beat; valid held until taken. Returns after the accepting edge.
  task automatic send_vertex(in_beat_t b, logic typed, out_beat_t typed_res);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
    n_beats_in++;
    if (b.last_vertex) n_polys++;
    clip_vertex(b);
    if (typed) pending_q.push_back(typed_res);
    else foreach (clip_q[i]) pending_q.push_back(clip_q[i]);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);  // a vertex with nothing to emit may still be busy
  endtask

  function automatic logic signed [CW-1:0] rnd_coord(logic wide_range);
    if (wide_range) return $urandom;
    return $signed($urandom_range(32'h8_0000)) - 32'sh4_0000;
  endfunction

  function automatic logic [DATA_W-1:0] rnd_reg(int mode);
    case (mode)
      0: return $signed($urandom_range(32'h4_0000)) - 32'sh2_0000;
      1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_beat_t mk_vtx(int x, int y, int z, logic lst);
    in_beat_t v;
    v.vx = x; v.vy = y; v.vz = z; v.last_vertex = lst;
    return v;
  endfunction

  dir_row_t dir_rows [$];

  initial begin
    out_beat_t none = '0;
    out_beat_t r;
    int        n_items, plen;
    logic      wide_range;
    in_beat_t  v;

    plane_n[0] = 0; plane_n[1] = 0; plane_n[2] = ONE_Q;
    plane_b[0] = 0; plane_b[1] = 0; plane_b[2] = 0;
    ref_z = ONE_Q;
    vert_pos = 0; prev_in = 1'b0;
    foreach (first_v[i]) begin
      first_v[i] = '0; second_v[i] = '0; prev_v[i] = '0;
    end

    // Directed set, run on the reset plane z = 0 with the inside above it.
    // Single vertex passes through.
    r = '0; r.ox = 32'h1_0000; r.oy = 32'h2_0000; r.oz = 32'h3_0000;
    r.end_of_run = 1'b1; r.end_of_polygon = 1'b1;
    dir_rows.push_back('{mk_vtx(32'h1_0000, 32'h2_0000, 32'h3_0000, 1'b1), 1'b1, r});
    // Single vertex at the coordinate extremes.
    r.ox = 32'h8000_0000; r.oy = 32'h7fff_ffff; r.oz = 32'h8000_0000;
    dir_rows.push_back('{mk_vtx(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b1),
                        1'b1, r});
    // Two-vertex polygon, extremes both ways.
    dir_rows.push_back('{mk_vtx(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0), 0, none});
    dir_rows.push_back('{mk_vtx(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b1), 0, none});
    // Triangle with one vertex inside: two crossings incl. the closing edge.
    dir_rows.push_back('{mk_vtx(0, 0, 32'h1_0000, 1'b0), 0, none});
    dir_rows.push_back('{mk_vtx(32'h2_0000, 0, -32'h1_0000, 1'b0), 0, none});
    dir_rows.push_back('{mk_vtx(0, 32'h2_0000, -32'h1_0000, 1'b1), 0, none});
    // Triangle wholly outside: empty final vertex.
    dir_rows.push_back('{mk_vtx(0, 0, -32'h1_0000, 1'b0), 0, none});
    dir_rows.push_back('{mk_vtx(32'h1_0000, 0, -32'h2_0000, 1'b0), 0, none});
    dir_rows.push_back('{mk_vtx(0, 32'h1_0000, -32'h3_0000, 1'b1), 0, none});
    // Quad with a vertex lying on the plane.
    dir_rows.push_back('{mk_vtx(0, 0, 32'h1_0000, 1'b0), 0, none});
    dir_rows.push_back('{mk_vtx(32'h1_0000, 0, 0, 1'b0), 0, none});
    dir_rows.push_back('{mk_vtx(32'h1_0000, 32'h1_0000, -32'h1_0000, 1'b0), 0, none});
    dir_rows.push_back('{mk_vtx(0, 32'h1_0000, 32'h1_8000, 1'b1), 0, none});
    // Five vertices starting outside, crossing in and out twice.
    dir_rows.push_back('{mk_vtx(0, 0, -32'h1_0000, 1'b0), 0, none});
    dir_rows.push_back('{mk_vtx(32'h1_0000, 0, 32'h3_0000, 1'b0), 0, none});
    dir_rows.push_back('{mk_vtx(32'h2_0000, 0, -32'h0_4000, 1'b0), 0, none});
    dir_rows.push_back('{mk_vtx(32'h2_0000, 32'h1_0000, 32'h0_0001, 1'b0), 0, none});
    dir_rows.push_back('{mk_vtx(-32'h3_0000, 32'h1_0000, -32'h7_0000, 1'b1), 0, none});

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    in_idle_pct = 21; out_idle_pct = 82;
    foreach (dir_rows[i]) send_vertex(dir_rows[i].v, dir_rows[i].typed, dir_rows[i].res);
    drain();

    // Random phases: new plane each time, idling profile moves on as we go.
    for (int ph = 0; ph < 8; ph++) begin
      int mode;
      if (ph < 3) begin in_idle_pct = 21; out_idle_pct = 82; end
      else if (ph < 6) begin in_idle_pct = 82; out_idle_pct = 21; end
      else begin in_idle_pct = 0; out_idle_pct = 0; end
      mode = (ph == 2) ? 1 : (ph == 5) ? 2 : 0;
      for (int k = 0; k < 7; k++) reg_write(RIDX_W'(k), rnd_reg(mode));
      n_items = 0;
      while (n_items < 36) begin
        plen = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 6);
        wide_range = (mode != 0) || ($urandom_range(15) == 0);
        for (int j = 0; j < plen; j++) begin
          v = mk_vtx(rnd_coord(wide_range), rnd_coord(wide_range),
                     rnd_coord(wide_range), j == plen - 1);
          send_vertex(v, 1'b0, none);
          n_items++;
        end
      end
      drain();
    end

    $display("covered %0d vertex beats in %0d polygons, %0d result beats (%0d crossings)",
             n_beats_in, n_polys, n_beats_out, n_isect);
    $display("nine plane set-ups incl. register extremes; %0d failures", n_fail);
    if (n_fail == 0 && pending_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
